[rtl/first_fit_extent_allocator_defines.svh]
// Assertion macros for the extent allocator.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define FFA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FFA_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define FFA_ASSERT(label, clk, rst_n, prop)
`define FFA_ASSERT_RST(label, clk, prop)
`endif
`endif

[rtl/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types, codes and defaults of the first-fit extent allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffa_pkg;
    localparam int MAX_EXTENTS_DEF = 64;
    localparam int PAGE_BYTES_DEF  = 4096;
    localparam int ADDR_BITS_DEF   = 32;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MISALIGN = 3'd1,
        ST_EXCEEDS  = 3'd2,
        ST_NOFIT    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] base_addr;
        logic [31:0] byte_count;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_addr;
        logic [32:0] free_total;
    } t_rsp;

    // Per-cycle command broadcast to every cell.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TRIM,     // base += n, size -= n at sel
        OP_GROW_DN,  // size += n at sel (merge with lower)
        OP_GROW_UP,  // base = a, size += n at sel
        OP_REMOVE,   // shift entries above sel down by one
        OP_INSERT,   // shift entries at/above sel up, write a/n at sel
        OP_ADD_NEXT  // size[sel] += n + size[sel+1] (two-sided merge)
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] a;
        logic [32:0] n;
    } t_cmd;

    function automatic logic [32:0] sat_add(input logic [32:0] x, input logic [32:0] y);
        logic [33:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[33] ? {33{1'b1}} : s[32:0];
    endfunction
endpackage
`default_nettype wire

[rtl/ffa_cell.sv]
// ----------------------------------------------------------------------------
// ffa_cell
// One table entry: holds base and size, compares against the request and
// takes its neighbor's contents on a shift.
// ----------------------------------------------------------------------------
`default_nettype none
module ffa_cell #(
    parameter int ADDR_BITS = ffa_pkg::ADDR_BITS_DEF,
    parameter int IDX_W     = 6
) (
    input  wire                  i_clk,
    input  wire [IDX_W-1:0]      i_idx,
    input  wire [IDX_W-1:0]      i_sel,
    input  ffa_pkg::t_cmd        i_cmd,
    input  wire [ADDR_BITS-1:0]  i_lo_base,
    input  wire [32:0]           i_lo_size,
    input  wire [ADDR_BITS-1:0]  i_hi_base,
    input  wire [32:0]           i_hi_size,
    output logic [ADDR_BITS-1:0] o_base,
    output logic [32:0]          o_size,
    output logic                 o_fits,
    output logic                 o_ge
);
    logic [ADDR_BITS-1:0] r_base;
    logic [32:0]          r_size;
    logic [ADDR_BITS-1:0] n_base;
    logic [32:0]          n_size;
    logic [ADDR_BITS-1:0] a_w;

    assign a_w    = i_cmd.a[ADDR_BITS-1:0];
    assign o_base = r_base;
    assign o_size = r_size;
    assign o_fits = (r_size >= i_cmd.n);
    assign o_ge   = (r_base >= a_w);

    always_comb begin
        n_base = r_base;
        n_size = r_size;
        unique case (i_cmd.op)
            ffa_pkg::OP_TRIM: if (i_idx == i_sel) begin
                n_base = r_base + ADDR_BITS'(i_cmd.n);
                n_size = r_size - i_cmd.n;
            end
            ffa_pkg::OP_GROW_DN: if (i_idx == i_sel) begin
                n_size = ffa_pkg::sat_add(r_size, i_cmd.n);
            end
            ffa_pkg::OP_GROW_UP: if (i_idx == i_sel) begin
                n_base = a_w;
                n_size = ffa_pkg::sat_add(r_size, i_cmd.n);
            end
            ffa_pkg::OP_ADD_NEXT: if (i_idx == i_sel) begin
                n_size = ffa_pkg::sat_add(ffa_pkg::sat_add(r_size, i_cmd.n), i_hi_size);
            end
            ffa_pkg::OP_REMOVE: if (i_idx >= i_sel) begin
                n_base = i_hi_base;
                n_size = i_hi_size;
            end
            ffa_pkg::OP_INSERT: begin
                if (i_idx == i_sel) begin
                    n_base = a_w;
                    n_size = i_cmd.n;
                end else if (i_idx > i_sel) begin
                    n_base = i_lo_base;
                    n_size = i_lo_size;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_size <= n_size;
    end
endmodule
`default_nettype wire

[rtl/first_fit_extent_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// First-fit extent allocator with coalescing over a row of extent cells.
// ----------------------------------------------------------------------------
// channel  | direction | handshake
// request  | in        | i_start high while o_busy low
// result   | out       | o_done strobe, one cycle
//
// An item passes through capture, a search over all cells in parallel, one
// table update, then the result step; a free that merges on both sides adds
// one more update. o_busy is high from the cycle after acceptance until o_done
// rises; the next item may be accepted in the o_done cycle.
// Reset clears the count and total; cell contents stay undefined until written.
// The receiver cannot stall; o_done lasts one cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_extent_allocator_defines.svh"
module first_fit_extent_allocator #(
    parameter int MAX_EXTENTS = ffa_pkg::MAX_EXTENTS_DEF,
    parameter int PAGE_BYTES  = ffa_pkg::PAGE_BYTES_DEF,
    parameter int ADDR_BITS   = ffa_pkg::ADDR_BITS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  ffa_pkg::t_req  i_req,
    output logic           o_busy,
    output logic           o_done,
    output ffa_pkg::t_rsp  o_rsp
);
    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_SEARCH, S_UPDATE, S_MERGE, S_DONE} t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic [32:0]          r_free;
    logic                 r_kind;
    logic [63:0]          r_a;
    logic [32:0]          r_n;
    logic [IDX_W-1:0]     r_sel;
    ffa_pkg::t_op         r_op;
    logic                 r_two;
    logic [2:0]           r_status;
    logic [31:0]          r_grant;

    logic [ADDR_BITS-1:0] w_base [MAX_EXTENTS];
    logic [32:0]          w_size [MAX_EXTENTS];
    logic [MAX_EXTENTS-1:0] w_fits, w_ge, w_live;
    ffa_pkg::t_cmd        w_cmd;

    always_comb begin
        w_cmd.op = ffa_pkg::OP_NONE;
        if (r_state == S_UPDATE) w_cmd.op = r_op;
        else if (r_state == S_MERGE) w_cmd.op = ffa_pkg::OP_REMOVE;
        w_cmd.a = r_a;
        w_cmd.n = r_n;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_EXTENTS; g++) begin : g_cell
            ffa_cell #(.ADDR_BITS(ADDR_BITS), .IDX_W(IDX_W)) u_cell (
                .i_clk    (i_clk),
                .i_idx    (IDX_W'(g)),
                .i_sel    (r_sel),
                .i_cmd    (w_cmd),
                .i_lo_base(w_base[(g == 0) ? 0 : g - 1]),
                .i_lo_size(w_size[(g == 0) ? 0 : g - 1]),
                .i_hi_base(w_base[(g == MAX_EXTENTS - 1) ? g : g + 1]),
                .i_hi_size(w_size[(g == MAX_EXTENTS - 1) ? g : g + 1]),
                .o_base   (w_base[g]),
                .o_size   (w_size[g]),
                .o_fits   (w_fits[g]),
                .o_ge     (w_ge[g])
            );
            assign w_live[g] = (CNT_W'(g) < r_count);
        end
    endgenerate

    // First-fit and insert position: lowest live index with the flag set.
    logic [MAX_EXTENTS-1:0] w_fit_v, w_ge_v;
    logic [IDX_W-1:0]       w_fit_i, w_pos_i;
    logic                   w_fit_any;
    logic [CNT_W-1:0]       w_pos;
    assign w_fit_v = w_fits & w_live;
    assign w_ge_v  = w_ge & w_live;
    always_comb begin
        w_fit_i = '0;
        w_pos_i = '0;
        for (int k = MAX_EXTENTS - 1; k >= 0; k--) begin
            if (w_fit_v[k]) w_fit_i = IDX_W'(k);
            if (w_ge_v[k])  w_pos_i = IDX_W'(k);
        end
    end
    assign w_fit_any = |w_fit_v;
    assign w_pos     = (|w_ge_v) ? CNT_W'(w_pos_i) : r_count;

    // Neighbor checks around the insert position.
    logic [IDX_W-1:0] w_dn_i, w_up_i;
    logic             w_down, w_up;
    logic [63:0]      w_end_dn, w_end_new;
    assign w_dn_i    = IDX_W'(w_pos - CNT_W'(1));
    assign w_up_i    = w_pos[IDX_W-1:0];
    assign w_end_dn  = 64'(w_base[w_dn_i]) + 64'(w_size[w_dn_i]);
    assign w_end_new = r_a + 64'(r_n);
    assign w_down    = (w_pos != '0) && (w_end_dn == r_a);
    assign w_up      = (w_pos < r_count) && (w_end_new == 64'(w_base[w_up_i]));

    logic w_misalign, w_abase, w_past;
    assign w_misalign = ((i_req.byte_count % PAGE_BYTES) != 0);
    assign w_abase    = ((r_a % PAGE_BYTES) != 0);
    assign w_past     = (w_end_new > (64'd1 << ADDR_BITS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_free  <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_kind   <= i_req.kind;
                    r_a      <= 64'(i_req.base_addr);
                    r_n      <= 33'(i_req.byte_count);
                    r_op     <= ffa_pkg::OP_NONE;
                    r_two    <= 1'b0;
                    r_grant  <= '0;
                    r_status <= w_misalign ? ffa_pkg::ST_MISALIGN : ffa_pkg::ST_OK;
                    r_state  <= S_SEARCH;
                end
                S_SEARCH: begin
                    r_state <= S_UPDATE;
                    if (r_status == ffa_pkg::ST_OK) begin
                        if (r_kind == ffa_pkg::KIND_ALLOC) begin
                            if (r_n > r_free) r_status <= ffa_pkg::ST_EXCEEDS;
                            else if (!w_fit_any) r_status <= ffa_pkg::ST_NOFIT;
                            else begin
                                r_sel   <= w_fit_i;
                                r_grant <= 32'(w_base[w_fit_i]);
                                r_free  <= r_free - r_n;
                                if (w_size[w_fit_i] == r_n) begin
                                    r_op    <= ffa_pkg::OP_REMOVE;
                                    r_count <= r_count - CNT_W'(1);
                                end else begin
                                    r_op <= ffa_pkg::OP_TRIM;
                                end
                            end
                        end else if (w_abase || w_past) begin
                            r_status <= ffa_pkg::ST_MISALIGN;
                        end else if (r_n != '0) begin
                            if (w_down && w_up) begin
                                r_sel   <= w_dn_i;
                                r_op    <= ffa_pkg::OP_ADD_NEXT;
                                r_two   <= 1'b1;
                                r_free  <= ffa_pkg::sat_add(r_free, r_n);
                            end else if (w_down) begin
                                r_sel  <= w_dn_i;
                                r_op   <= ffa_pkg::OP_GROW_DN;
                                r_free <= ffa_pkg::sat_add(r_free, r_n);
                            end else if (w_up) begin
                                r_sel  <= w_up_i;
                                r_op   <= ffa_pkg::OP_GROW_UP;
                                r_free <= ffa_pkg::sat_add(r_free, r_n);
                            end else if (r_count >= CNT_W'(MAX_EXTENTS)) begin
                                r_status <= ffa_pkg::ST_FULL;
                            end else begin
                                r_sel   <= w_up_i;
                                r_op    <= ffa_pkg::OP_INSERT;
                                r_count <= r_count + CNT_W'(1);
                                r_free  <= ffa_pkg::sat_add(r_free, r_n);
                            end
                        end
                    end
                end
                S_UPDATE: begin
                    if (r_two) begin
                        // lower takes the merged size in this update; the merge state drops the upper entry
                        r_state <= S_MERGE;
                        r_sel   <= r_sel + IDX_W'(1);
                        r_count <= r_count - CNT_W'(1);
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_MERGE: r_state <= S_DONE;
                S_DONE: begin
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    always_comb begin
        o_rsp.status       = r_status;
        o_rsp.granted_addr = (r_status == ffa_pkg::ST_OK) ? r_grant : '0;
        o_rsp.free_total   = r_free;
    end

    `FFA_ASSERT(a_count_max, i_clk, i_rst_n, r_count <= CNT_W'(MAX_EXTENTS))
    `FFA_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> r_state == S_IDLE)
    `FFA_ASSERT(a_grant_fail, i_clk, i_rst_n, (o_done && o_rsp.status != ffa_pkg::ST_OK) |-> o_rsp.granted_addr == '0)
    `FFA_ASSERT_RST(a_start_busy, i_clk, (i_rst_n && i_start && !o_busy) |=> o_busy || !i_rst_n)
endmodule
`default_nettype wire
